### hw/rtl/fdc_pkg.sv
// Shared types, codes and constant tables for the frame deframer with CRC-32 check.
`default_nettype none

package fdc_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_START_MARKER    = 1'b0,
        REG_MAX_BODY_LENGTH = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_NO_MARKER      = 3'd1,
        ST_BAD_COMMAND    = 3'd2,
        ST_BAD_GUID       = 3'd3,
        ST_NUMBER_OVER    = 3'd4,
        ST_CRC_MISMATCH   = 3'd5,
        ST_BODY_TOO_LONG  = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        CMD_COMMAND      = 3'd0,
        CMD_ACK          = 3'd1,
        CMD_RECEIVED     = 3'd2,
        CMD_AUTHRESPONSE = 3'd3,
        CMD_RESPONSE     = 3'd4
    } command_t;

    typedef enum logic {
        KIND_BODY    = 1'b0,
        KIND_VERDICT = 1'b1
    } item_kind_t;

    localparam int NUM_CMDS = 5;
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Command names, last character in the lowest byte.
    localparam logic [95:0] CMD_TEXT [NUM_CMDS] = '{
        96'("COMMAND"), 96'("ACK"), 96'("RECEIVED"), 96'("AUTHRESPONSE"), 96'("RESPONSE")
    };
    localparam logic [3:0] CMD_LEN [NUM_CMDS] = '{4'd7, 4'd3, 4'd8, 4'd12, 4'd8};

    typedef struct packed {
        logic [7:0]  start_marker;
        logic [31:0] max_body_length;
    } cfg_t;

    // Result payload, last field in the lowest bits.
    typedef struct packed {
        logic [31:0] body_length;
        logic [31:0] frame_count;
        logic [31:0] frame_number;
        logic [2:0]  command_code;
        logic [2:0]  verdict_status;
        logic [7:0]  body_byte;
    } out_item_t;

    // Character of a command name at a position; zero past the end of the name.
    function automatic logic [7:0] name_char(input logic [2:0] k, input logic [7:0] idx);
        logic [3:0] len;
        logic [3:0] pos;
        len = CMD_LEN[k];
        pos = len - 4'd1 - idx[3:0];
        if (idx >= {4'd0, len})
            return 8'd0;
        return CMD_TEXT[k][{pos, 3'b000} +: 8];
    endfunction

    function automatic logic is_hex(input logic [7:0] b);
        return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
               (b >= 8'h61 && b <= 8'h66);
    endfunction

    // Lowest surviving candidate wins; none left reads as the first command.
    function automatic logic [2:0] cmd_code(input logic [NUM_CMDS-1:0] cand);
        logic [2:0] code;
        code = CMD_COMMAND;
        for (int k = NUM_CMDS - 1; k >= 0; k--)
            if (cand[k])
                code = 3'(k);
        return code;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/fdc_crc.sv
// Bytewise update of the reflected CRC-32.
`default_nettype none

module fdc_crc (
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic [31:0]      crc_out
);

    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ fdc_pkg::CRC_POLY) : (c >> 1);
        crc_out = c;
    end

endmodule

`default_nettype wire

### hw/rtl/fdc_parser.sv
// Frame parser: header fields, name and GUID checks, body forwarding, verdict register.
`default_nettype none

module fdc_parser #(
    parameter int NAME_FIELD_LEN     = 16,
    parameter int GUID_FIELD_LEN     = 32,
    parameter int RESERVED_FIELD_LEN = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               step,
    input  wire logic [7:0]         step_byte,
    input  wire fdc_pkg::cfg_t      cfg,
    input  wire logic               out_ready,
    output logic                    res_valid,
    output fdc_pkg::item_kind_t     res_kind,
    output fdc_pkg::out_item_t      res
);

    localparam int IDX_MAX0 = (NAME_FIELD_LEN > GUID_FIELD_LEN) ? NAME_FIELD_LEN
                                                                : GUID_FIELD_LEN;
    localparam int IDX_MAX1 = (IDX_MAX0 > RESERVED_FIELD_LEN) ? IDX_MAX0 : RESERVED_FIELD_LEN;
    localparam int IDX_MAX  = (IDX_MAX1 > 4) ? IDX_MAX1 : 4;
    localparam int IDX_W    = $clog2(IDX_MAX);
    localparam int RES_LAST = (RESERVED_FIELD_LEN > 0) ? RESERVED_FIELD_LEN - 1 : 0;

    typedef enum logic [3:0] {
        PH_ARMED    = 4'd0,
        PH_SILENT   = 4'd1,
        PH_NAME     = 4'd2,
        PH_GUID     = 4'd3,
        PH_NUMBER   = 4'd4,
        PH_COUNT    = 4'd5,
        PH_RESERVED = 4'd6,
        PH_LENGTH   = 4'd7,
        PH_BODY     = 4'd8,
        PH_CRC      = 4'd9,
        PH_FOOTER   = 4'd10
    } phase_t;

    phase_t                          phase_reg, phase_next;
    logic [IDX_W-1:0]                idx_reg, idx_next;
    logic [31:0]                     crc_reg, crc_next;
    logic [31:0]                     word_reg, word_next;
    logic [fdc_pkg::NUM_CMDS-1:0]    cand_reg, cand_next;
    logic                            ended_reg, ended_next;
    logic                            guid_bad_reg, guid_bad_next;
    logic [31:0]                     number_reg, number_next;
    logic [31:0]                     count_reg, count_next;
    logic [31:0]                     length_reg, length_next;
    logic [31:0]                     remain_reg, remain_next;
    logic                            res_valid_reg;
    fdc_pkg::item_kind_t             kind_reg, kind_next;
    fdc_pkg::out_item_t              res_reg, res_next;
    logic                            emit;

    logic                            in_crc_span;
    logic [31:0]                     crc_seed;
    logic [31:0]                     crc_upd;
    logic [31:0]                     word_shifted;

    assign in_crc_span  = (phase_reg >= PH_NAME) && (phase_reg <= PH_BODY);
    // Outside a frame the CRC restarts from all ones with the marker byte.
    assign crc_seed     = in_crc_span ? crc_reg : 32'hFFFF_FFFF;
    assign word_shifted = {step_byte, word_reg[31:8]};

    fdc_crc u_crc (
        .crc_in  (crc_seed),
        .data    (step_byte),
        .crc_out (crc_upd)
    );

    always_comb
    begin
        logic                         give_verdict;
        logic [2:0]                   vstat;
        logic [2:0]                   vcmd;
        logic [fdc_pkg::NUM_CMDS-1:0] cand_upd;
        logic                         ended_upd;

        phase_next    = phase_reg;
        idx_next      = idx_reg;
        crc_next      = in_crc_span ? crc_upd : crc_reg;
        word_next     = word_reg;
        cand_next     = cand_reg;
        ended_next    = ended_reg;
        guid_bad_next = guid_bad_reg;
        number_next   = number_reg;
        count_next    = count_reg;
        length_next   = length_reg;
        remain_next   = remain_reg;
        emit          = 1'b0;
        kind_next     = fdc_pkg::KIND_BODY;
        res_next      = '0;
        give_verdict  = 1'b0;
        vstat         = fdc_pkg::ST_OK;
        vcmd          = fdc_pkg::cmd_code(cand_reg);
        cand_upd      = cand_reg;
        ended_upd     = ended_reg;

        unique case (phase_reg)
            PH_NAME:
            begin
                if (!ended_reg)
                begin
                    for (int k = 0; k < fdc_pkg::NUM_CMDS; k++)
                    begin
                        if (step_byte == 8'd0)
                        begin
                            if (8'(fdc_pkg::CMD_LEN[k]) != 8'(idx_reg))
                                cand_upd[k] = 1'b0;
                        end
                        else if (fdc_pkg::name_char(3'(k), 8'(idx_reg)) != step_byte)
                            cand_upd[k] = 1'b0;
                    end
                    if (step_byte == 8'd0)
                        ended_upd = 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(NAME_FIELD_LEN - 1))
                begin
                    // A name that fills the field without a NUL must be exactly that long.
                    if (!ended_upd)
                        for (int k = 0; k < fdc_pkg::NUM_CMDS; k++)
                            if (32'(fdc_pkg::CMD_LEN[k]) != 32'(NAME_FIELD_LEN))
                                cand_upd[k] = 1'b0;
                    phase_next = PH_GUID;
                    idx_next   = '0;
                    if (cand_upd == '0)
                    begin
                        give_verdict = 1'b1;
                        vstat        = fdc_pkg::ST_BAD_COMMAND;
                        vcmd         = fdc_pkg::CMD_COMMAND;
                    end
                end
                cand_next  = cand_upd;
                ended_next = ended_upd;
            end
            PH_GUID:
            begin
                guid_bad_next = guid_bad_reg | ~fdc_pkg::is_hex(step_byte);
                idx_next      = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(GUID_FIELD_LEN - 1))
                begin
                    phase_next = PH_NUMBER;
                    idx_next   = '0;
                    if (guid_bad_next)
                    begin
                        give_verdict = 1'b1;
                        vstat        = fdc_pkg::ST_BAD_GUID;
                    end
                end
            end
            PH_NUMBER, PH_COUNT, PH_LENGTH:
            begin
                word_next = word_shifted;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(3))
                begin
                    idx_next = '0;
                    if (phase_reg == PH_NUMBER)
                    begin
                        number_next = word_shifted;
                        phase_next  = PH_COUNT;
                    end
                    else if (phase_reg == PH_COUNT)
                    begin
                        count_next = word_shifted;
                        phase_next = (RESERVED_FIELD_LEN > 0) ? PH_RESERVED : PH_LENGTH;
                        if (number_reg > word_shifted)
                        begin
                            give_verdict = 1'b1;
                            vstat        = fdc_pkg::ST_NUMBER_OVER;
                        end
                    end
                    else
                    begin
                        length_next = word_shifted;
                        remain_next = word_shifted;
                        phase_next  = (word_shifted != 32'd0) ? PH_BODY : PH_CRC;
                        if (word_shifted > cfg.max_body_length)
                        begin
                            give_verdict = 1'b1;
                            vstat        = fdc_pkg::ST_BODY_TOO_LONG;
                        end
                    end
                end
            end
            PH_RESERVED:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(RES_LAST))
                begin
                    phase_next = PH_LENGTH;
                    idx_next   = '0;
                end
            end
            PH_BODY:
            begin
                emit               = 1'b1;
                res_next.body_byte = step_byte;
                remain_next        = remain_reg - 32'd1;
                if (remain_reg == 32'd1)
                begin
                    phase_next = PH_CRC;
                    idx_next   = '0;
                end
            end
            PH_CRC:
            begin
                word_next = word_shifted;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(3))
                begin
                    phase_next = PH_FOOTER;
                    idx_next   = '0;
                end
            end
            PH_FOOTER:
            begin
                give_verdict = 1'b1;
                vstat        = ((~crc_reg) == word_reg) ? fdc_pkg::ST_OK
                                                         : fdc_pkg::ST_CRC_MISMATCH;
            end
            default:
            begin
                if (step_byte == cfg.start_marker)
                begin
                    phase_next    = PH_NAME;
                    idx_next      = '0;
                    crc_next      = crc_upd;
                    word_next     = '0;
                    cand_next     = '1;
                    ended_next    = 1'b0;
                    guid_bad_next = 1'b0;
                    number_next   = '0;
                    count_next    = '0;
                    length_next   = '0;
                    remain_next   = '0;
                end
                else if (phase_reg != PH_SILENT)
                begin
                    // First stray byte after reset or a frame's verdict reports once, then the hunt is quiet.
                    number_next  = '0;
                    count_next   = '0;
                    length_next  = '0;
                    give_verdict = 1'b1;
                    vstat        = fdc_pkg::ST_NO_MARKER;
                    vcmd         = fdc_pkg::CMD_COMMAND;
                end
            end
        endcase

        if (give_verdict)
        begin
            emit                    = 1'b1;
            kind_next               = fdc_pkg::KIND_VERDICT;
            res_next.verdict_status = vstat;
            res_next.command_code   = vcmd;
            res_next.frame_number   = number_next;
            res_next.frame_count    = count_next;
            res_next.body_length    = length_next;
            phase_next              = (vstat == fdc_pkg::ST_NO_MARKER) ? PH_SILENT : PH_ARMED;
            idx_next                = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ARMED;
            idx_reg       <= '0;
            crc_reg       <= 32'hFFFF_FFFF;
            word_reg      <= '0;
            cand_reg      <= '1;
            ended_reg     <= 1'b0;
            guid_bad_reg  <= 1'b0;
            number_reg    <= '0;
            count_reg     <= '0;
            length_reg    <= '0;
            remain_reg    <= '0;
            res_valid_reg <= 1'b0;
            kind_reg      <= fdc_pkg::KIND_BODY;
            res_reg       <= '0;
        end
        else
        begin
            if (step && emit)
                res_valid_reg <= 1'b1;
            else if (out_ready)
                res_valid_reg <= 1'b0;
            if (step)
            begin
                phase_reg    <= phase_next;
                idx_reg      <= idx_next;
                crc_reg      <= crc_next;
                word_reg     <= word_next;
                cand_reg     <= cand_next;
                ended_reg    <= ended_next;
                guid_bad_reg <= guid_bad_next;
                number_reg   <= number_next;
                count_reg    <= count_next;
                length_reg   <= length_next;
                remain_reg   <= remain_next;
                if (emit)
                begin
                    kind_reg <= kind_next;
                    res_reg  <= res_next;
                end
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_kind  = kind_reg;
    assign res       = res_reg;

endmodule

`default_nettype wire

### hw/rtl/frame_deframer_crc32_check_top.sv
// Top level of the frame deframer with CRC-32 check: ports, input stage, configuration.
//
//   channel   direction  item                       tdata / tuser
//   s_axis    in         one received byte          tdata[7:0] rx_byte
//   m_axis    out        body byte or frame verdict tdata payload, tuser item_kind
//   cfg       in         register write             cfg_index selects, cfg_wdata
//
// One item is taken per cycle whenever the output side keeps up; each item passes
// through the input register and then the result register.
// The per-byte CRC update and the field counters sit between those two registers.
// A stalled output register holds the input register, and both back up the input.
// rst_n clears the parser to hunting for the start marker, start_marker to 0 and
// max_body_length to 65536.
`default_nettype none

module frame_deframer_crc32_check_top #(
    parameter int NAME_FIELD_LEN     = 16,
    parameter int GUID_FIELD_LEN     = 32,
    parameter int RESERVED_FIELD_LEN = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [7:0]   s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [7:0] body_byte, [10:8] verdict_status, [13:11] command_code,
    // [45:14] frame_number, [77:46] frame_count, [109:78] body_length, [111:110] zero
    output logic [111:0]      m_tdata,
    output logic              m_tuser,   // [0] item_kind
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_wdata
);

    fdc_pkg::cfg_t        cfg_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 advance;
    fdc_pkg::item_kind_t  res_kind;
    fdc_pkg::out_item_t   res;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker    <= 8'd0;
            cfg_reg.max_body_length <= 32'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fdc_pkg::REG_START_MARKER:    cfg_reg.start_marker    <= cfg_wdata[7:0];
                fdc_pkg::REG_MAX_BODY_LENGTH: cfg_reg.max_body_length <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= 8'd0;
        end
        else if (s_tvalid && s_tready)
        begin
            in_valid_reg <= 1'b1;
            in_byte_reg  <= s_tdata;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    fdc_parser #(
        .NAME_FIELD_LEN     (NAME_FIELD_LEN),
        .GUID_FIELD_LEN     (GUID_FIELD_LEN),
        .RESERVED_FIELD_LEN (RESERVED_FIELD_LEN)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .step_byte (in_byte_reg),
        .cfg       (cfg_reg),
        .out_ready (m_tready),
        .res_valid (m_tvalid),
        .res_kind  (res_kind),
        .res       (res)
    );

    assign m_tdata = {2'b00, res};
    assign m_tuser = res_kind;

    // A forwarded body byte never carries verdict fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fdc_pkg::KIND_BODY) |-> (m_tdata[111:8] == '0))
    else $error("body item carries verdict fields");

    // Verdict status stays within its defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == fdc_pkg::KIND_VERDICT) |-> (m_tdata[10:8] != 3'd7))
    else $error("verdict status out of range");

    // A waiting input byte is neither lost nor changed while the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
    else $error("input byte dropped while stalled");

    // The parser only steps when the result register can take a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!m_tvalid || m_tready) && !s_tready == 1'b0)
    else $error("parser stepped into a full result register");

endmodule

`default_nettype wire

### tb/tb_frame_deframer_crc32_check_top.sv
// Testbench for the frame deframer with CRC-32 check: frame builder, predictor and checker.
module tb_frame_deframer_crc32_check_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NAME_LEN = 16;
    localparam int GUID_CHARS = 32;
    localparam int RSV_LEN = 8;
    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 520;
    localparam logic [31:0] CRC32_REFLECTED_POLY = 32'hEDB8_8320;
    localparam string HEX_CHARS = "0123456789abcdefABCDEF";

    typedef enum logic [3:0] {
        P_HUNT, P_QUIET, P_NAME, P_GUID, P_NUMBER, P_COUNT,
        P_RESERVED, P_LENGTH, P_BODY, P_CRC, P_FOOTER
    } parse_phase_t;

    typedef enum int {
        NAME_EXACT, NAME_JUNK_AFTER_NUL, NAME_TYPO, NAME_NO_NUL
    } name_form_t;

    typedef struct packed {
        fdc_pkg::item_kind_t kind;
        logic [7:0]          body;
        fdc_pkg::status_t    status;
        fdc_pkg::command_t   cmd;
        logic [31:0]         number;
        logic [31:0]         count;
        logic [31:0]         length;
    } deframer_result_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [111:0] m_tdata;
    logic         m_tuser;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [31:0]  cfg_wdata;

    frame_deframer_crc32_check_top #(
        .NAME_FIELD_LEN(NAME_LEN),
        .GUID_FIELD_LEN(GUID_CHARS),
        .RESERVED_FIELD_LEN(RSV_LEN)
    ) dut (.*);

    string cmd_strings [5] = '{"COMMAND", "ACK", "RECEIVED", "AUTHRESPONSE", "RESPONSE"};

    // Mirror of the configuration and of the parser state.
    logic [7:0]   marker_cfg;
    logic [31:0]  max_len_cfg;
    parse_phase_t ph;
    int           fidx;
    logic [31:0]  crc_acc;
    logic [31:0]  shift_word;
    logic [4:0]   alive;
    bit           name_ended;
    bit           guid_err;
    logic [31:0]  num_h;
    logic [31:0]  cnt_h;
    logic [31:0]  len_h;
    logic [31:0]  body_left;

    deframer_result_t pending_results[$];
    logic [7:0]       frame_bytes[$];
    logic [31:0]      frame_crc;

    bit pace_tx;
    bit stall_rx;
    int failures;
    int bytes_sent;
    int body_seen;
    int verdicts_seen;
    int status_seen [8];

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        c ^= {24'd0, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC32_REFLECTED_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic bit is_hex_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f");
    endfunction

    function automatic fdc_pkg::command_t surviving_command();
        fdc_pkg::command_t code;
        code = fdc_pkg::CMD_COMMAND;
        for (int k = 4; k >= 0; k--)
            if (alive[k])
                code = fdc_pkg::command_t'(k);
        return code;
    endfunction

    function automatic void reset_predictor();
        marker_cfg = 8'd0;
        max_len_cfg = 32'd65536;
        ph = P_HUNT;
        fidx = 0;
        crc_acc = '1;
        shift_word = '0;
        alive = '1;
        name_ended = 1'b0;
        guid_err = 1'b0;
        num_h = '0;
        cnt_h = '0;
        len_h = '0;
        body_left = '0;
    endfunction

    function automatic void expect_verdict(input fdc_pkg::status_t st,
                                           input fdc_pkg::command_t cmd);
        deframer_result_t r;
        r.kind = fdc_pkg::KIND_VERDICT;
        r.body = 8'd0;
        r.status = st;
        r.cmd = cmd;
        r.number = num_h;
        r.count = cnt_h;
        r.length = len_h;
        pending_results.push_back(r);
        ph = P_HUNT;
        fidx = 0;
    endfunction

    // Advances the parser mirror by one accepted byte and queues what it produces.
    function automatic void predict_byte(input logic [7:0] b);
        deframer_result_t r;
        if (ph >= P_NAME && ph <= P_BODY)
            crc_acc = crc32_step(crc_acc, b);
        case (ph)
            P_NAME:
            begin
                if (!name_ended)
                begin
                    for (int k = 0; k < 5; k++)
                        if (b == 8'd0 ? (cmd_strings[k].len() != fidx)
                                      : (fidx >= cmd_strings[k].len() ||
                                         cmd_strings[k][fidx] != b))
                            alive[k] = 1'b0;
                    if (b == 8'd0)
                        name_ended = 1'b1;
                end
                fidx++;
                if (fidx >= NAME_LEN)
                begin
                    // A name that never ended must fill the whole field exactly.
                    if (!name_ended)
                        for (int k = 0; k < 5; k++)
                            if (cmd_strings[k].len() != NAME_LEN)
                                alive[k] = 1'b0;
                    if (alive == '0)
                        expect_verdict(fdc_pkg::ST_BAD_COMMAND, fdc_pkg::CMD_COMMAND);
                    else
                    begin
                        ph = P_GUID;
                        fidx = 0;
                    end
                end
            end
            P_GUID:
            begin
                if (!is_hex_digit(b))
                    guid_err = 1'b1;
                fidx++;
                if (fidx >= GUID_CHARS)
                begin
                    if (guid_err)
                        expect_verdict(fdc_pkg::ST_BAD_GUID, surviving_command());
                    else
                    begin
                        ph = P_NUMBER;
                        fidx = 0;
                    end
                end
            end
            P_NUMBER, P_COUNT, P_LENGTH:
            begin
                shift_word = {b, shift_word[31:8]};
                fidx++;
                if (fidx == 4)
                begin
                    fidx = 0;
                    if (ph == P_NUMBER)
                    begin
                        num_h = shift_word;
                        ph = P_COUNT;
                    end
                    else if (ph == P_COUNT)
                    begin
                        cnt_h = shift_word;
                        if (num_h > cnt_h)
                            expect_verdict(fdc_pkg::ST_NUMBER_OVER, surviving_command());
                        else
                            ph = (RSV_LEN > 0) ? P_RESERVED : P_LENGTH;
                    end
                    else
                    begin
                        len_h = shift_word;
                        if (len_h > max_len_cfg)
                            expect_verdict(fdc_pkg::ST_BODY_TOO_LONG, surviving_command());
                        else
                        begin
                            body_left = len_h;
                            ph = (body_left != 0) ? P_BODY : P_CRC;
                        end
                    end
                end
            end
            P_RESERVED:
            begin
                fidx++;
                if (fidx >= RSV_LEN)
                begin
                    ph = P_LENGTH;
                    fidx = 0;
                end
            end
            P_BODY:
            begin
                r = '0;
                r.kind = fdc_pkg::KIND_BODY;
                r.body = b;
                pending_results.push_back(r);
                body_left--;
                if (body_left == 0)
                begin
                    ph = P_CRC;
                    fidx = 0;
                end
            end
            P_CRC:
            begin
                shift_word = {b, shift_word[31:8]};
                fidx++;
                if (fidx >= 4)
                begin
                    ph = P_FOOTER;
                    fidx = 0;
                end
            end
            P_FOOTER:
                expect_verdict((~crc_acc == shift_word) ? fdc_pkg::ST_OK
                                                        : fdc_pkg::ST_CRC_MISMATCH,
                               surviving_command());
            default:
            begin
                if (b == marker_cfg)
                begin
                    ph = P_NAME;
                    fidx = 0;
                    crc_acc = crc32_step('1, b);
                    shift_word = '0;
                    alive = '1;
                    name_ended = 1'b0;
                    guid_err = 1'b0;
                    num_h = '0;
                    cnt_h = '0;
                    len_h = '0;
                    body_left = '0;
                end
                else if (ph != P_QUIET)
                begin
                    num_h = '0;
                    cnt_h = '0;
                    len_h = '0;
                    expect_verdict(fdc_pkg::ST_NO_MARKER, fdc_pkg::CMD_COMMAND);
                    ph = P_QUIET;
                end
            end
        endcase
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
        frame_crc = crc32_step(frame_crc, b);
    endfunction

    function automatic void put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            put_byte(w[8*i +: 8]);
    endfunction

    function automatic logic [7:0] random_non_hex();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (is_hex_digit(b));
        return b;
    endfunction

    // Builds one frame under the current settings; a frame that the block will
    // reject in its header stops right after the offending field.
    function automatic void build_frame(input int cmd, input name_form_t form,
                                        input bit bad_guid, input logic [31:0] num,
                                        input logic [31:0] cnt, input logic [31:0] len,
                                        input bit bad_crc);
        string nm;
        int pos;
        logic [7:0] c;
        logic [31:0] sent_crc;
        nm = cmd_strings[cmd];
        frame_bytes.delete();
        frame_crc = '1;
        put_byte(marker_cfg);
        pos = (form == NAME_TYPO) ? $urandom_range(0, nm.len() - 1) : -1;
        for (int i = 0; i < NAME_LEN; i++)
        begin
            if (form == NAME_NO_NUL)
                c = 8'($urandom_range(1, 255));
            else if (i < nm.len())
                c = (i == pos) ? (nm[i] ^ 8'($urandom_range(1, 255))) : nm[i];
            else if (i == nm.len() || form != NAME_JUNK_AFTER_NUL)
                c = 8'd0;
            else
                c = 8'($urandom_range(0, 255));
            put_byte(c);
        end
        if (form == NAME_TYPO || form == NAME_NO_NUL)
            return;
        pos = bad_guid ? $urandom_range(0, GUID_CHARS - 1) : -1;
        for (int i = 0; i < GUID_CHARS; i++)
            put_byte(i == pos ? random_non_hex() : HEX_CHARS[$urandom_range(0, 21)]);
        if (bad_guid)
            return;
        put_word(num);
        put_word(cnt);
        if (num > cnt)
            return;
        repeat (RSV_LEN)
            put_byte(8'($urandom_range(0, 255)));
        put_word(len);
        if (len > max_len_cfg)
            return;
        repeat (len)
            put_byte(8'($urandom_range(0, 255)));
        sent_crc = ~frame_crc ^ (bad_crc ? (32'd1 << $urandom_range(0, 31)) : 32'd0);
        for (int i = 0; i < 4; i++)
            frame_bytes.push_back(sent_crc[8*i +: 8]);
        frame_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic int pick_gap();
        int r;
        if (!pace_tx)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input int upto);
        for (int i = 0; i < frame_bytes.size() && i < upto; i++)
            send_byte(frame_bytes[i]);
    endtask

    task automatic send_built(input int cmd, input name_form_t form, input bit bad_guid,
                              input logic [31:0] num, input logic [31:0] cnt,
                              input logic [31:0] len, input bit bad_crc);
        build_frame(cmd, form, bad_guid, num, cnt, len, bad_crc);
        send_frame(frame_bytes.size());
    endtask

    task automatic drain_pipeline();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        // A byte that makes no result may still sit in the two pipeline registers.
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(input fdc_pkg::reg_index_t idx, input logic [31:0] value);
        drain_pipeline();
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == fdc_pkg::REG_START_MARKER)
            marker_cfg = value[7:0];
        else
            max_len_cfg = value;
    endtask

    task automatic test_missing_marker();
        pace_tx = 1'b0;
        stall_rx = 1'b0;
        // Only the first stray byte gives a verdict; the rest are dropped.
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'h01);
        send_built(fdc_pkg::CMD_ACK, NAME_EXACT, 1'b0, 32'd0, 32'd0, 32'd0, 1'b0);
    endtask

    task automatic test_command_names();
        pace_tx = 1'b1;
        stall_rx = 1'b1;
        // A broken GUID ends each frame early, and its verdict still names the command.
        send_built(fdc_pkg::CMD_RECEIVED, NAME_JUNK_AFTER_NUL, 1'b1, 32'd3, 32'd9, 32'd5,
                   1'b0);
        send_built(fdc_pkg::CMD_RESPONSE, NAME_EXACT, 1'b1, 32'd0, 32'd1, 32'd2, 1'b0);
    endtask

    task automatic test_header_errors();
        send_built(fdc_pkg::CMD_RECEIVED, NAME_TYPO, 1'b0, 32'd0, 32'd1, 32'd0, 1'b0);
        send_built(fdc_pkg::CMD_COMMAND, NAME_NO_NUL, 1'b0, 32'd0, 32'd1, 32'd0, 1'b0);
        send_built(fdc_pkg::CMD_COMMAND, NAME_EXACT, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                   32'd0, 1'b0);
    endtask

    task automatic test_body_limit();
        write_register(fdc_pkg::REG_MAX_BODY_LENGTH, 32'd4);
        // A body exactly at the limit passes the length check; its CRC is broken.
        send_built(fdc_pkg::CMD_COMMAND, NAME_EXACT, 1'b0, 32'd2, 32'd2, 32'd4, 1'b1);
        send_built(fdc_pkg::CMD_RESPONSE, NAME_EXACT, 1'b0, 32'd0, 32'd0, 32'd5, 1'b0);
    endtask

    task automatic test_marker_values();
        write_register(fdc_pkg::REG_START_MARKER, 32'h0000_00FF);
        // The old marker value now counts as a stray byte.
        send_byte(8'h00);
        send_built(fdc_pkg::CMD_AUTHRESPONSE, NAME_EXACT, 1'b1, 32'd0, 32'd3, 32'd3, 1'b0);
    endtask

    task automatic test_random_traffic();
        int frames;
        int r;
        int cmd;
        logic [7:0] b;
        logic [31:0] cap;
        logic [31:0] num;
        logic [31:0] cnt;
        logic [31:0] len;
        frames = 0;
        while (bytes_sent < ITEM_TARGET || frames < 2)
        begin
            write_register(fdc_pkg::REG_START_MARKER, $urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: cap = 32'd0;
                1: cap = $urandom_range(1, 40);
                2: cap = 32'd65536;
                default: cap = 32'hFFFF_FFFF;
            endcase
            write_register(fdc_pkg::REG_MAX_BODY_LENGTH, cap);
            pace_tx = ($urandom_range(0, 3) != 0);
            stall_rx = ($urandom_range(0, 3) != 0);
            cmd = $urandom_range(0, 4);
            cnt = pick_word();
            num = $urandom_range(0, cnt);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64)
                                              : $urandom_range(0, 16);
            if (len > cap)
                len = cap;
            r = $urandom_range(0, 99);
            if (r < 55 || (r >= 85 && r < 92 && cap == 32'hFFFF_FFFF))
                send_built(cmd, NAME_EXACT, 1'b0, num, cnt, len, 1'b0);
            else if (r < 63)
                send_built(cmd, NAME_EXACT, 1'b0, num, cnt, len, 1'b1);
            else if (r < 71)
                send_built(cmd, name_form_t'($urandom_range(1, 3)), 1'b0, num, cnt,
                           len, 1'b0);
            else if (r < 78)
                send_built(cmd, NAME_EXACT, 1'b1, num, cnt, len, 1'b0);
            else if (r < 85)
            begin
                if (cnt == 32'hFFFF_FFFF)
                    cnt = $urandom_range(0, 32'hFFFF_FFFE);
                send_built(cmd, NAME_EXACT, 1'b0, $urandom_range(cnt + 1, 32'hFFFF_FFFF),
                           cnt, len, 1'b0);
            end
            else if (r < 92)
                send_built(cmd, NAME_EXACT, 1'b0, num, cnt,
                           $urandom_range(cap + 1, 32'hFFFF_FFFF), 1'b0);
            else if (r < 97)
                repeat ($urandom_range(1, 6))
                begin
                    do
                        b = 8'($urandom_range(0, 255));
                    while (b == marker_cfg);
                    send_byte(b);
                end
            else
            begin
                // Frame broken off inside its name, then a filler byte that is
                // neither hex nor NUL forces a verdict and a return to hunting.
                build_frame(cmd, NAME_EXACT, 1'b0, num, cnt, len, 1'b0);
                send_frame($urandom_range(1, NAME_LEN));
                b = (marker_cfg == 8'h01) ? 8'h02 : 8'h01;
                repeat (NAME_LEN + GUID_CHARS + 1)
                    send_byte(b);
            end
            frames++;
        end
    endtask

    function automatic void compare_field(input string field, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, field, want, got);
            failures++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        deframer_result_t got;
        deframer_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = fdc_pkg::item_kind_t'(m_tuser);
            got.body = m_tdata[7:0];
            got.status = fdc_pkg::status_t'(m_tdata[10:8]);
            got.cmd = fdc_pkg::command_t'(m_tdata[13:11]);
            got.number = m_tdata[45:14];
            got.count = m_tdata[77:46];
            got.length = m_tdata[109:78];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected item: expected none actual kind %0d tdata %h",
                         $time, m_tuser, m_tdata);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("item_kind", want.kind, got.kind);
                compare_field("body_byte", want.body, got.body);
                compare_field("verdict_status", want.status, got.status);
                compare_field("command_code", want.cmd, got.cmd);
                compare_field("frame_number", want.number, got.number);
                compare_field("frame_count", want.count, got.count);
                compare_field("body_length", want.length, got.length);
                if (want.kind == fdc_pkg::KIND_BODY)
                    body_seen++;
                else
                begin
                    verdicts_seen++;
                    status_seen[want.status]++;
                end
            end
        end
    end

    initial
    begin
        int hold;
        m_tready = 1'b1;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!stall_rx || $urandom_range(0, 99) < 75)
                m_tready = 1'b1;
            else
            begin
                m_tready = 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                                                   : $urandom_range(0, 2);
                repeat (hold) @(negedge clk);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'd0;
        cfg_we = 1'b0;
        cfg_index = fdc_pkg::REG_START_MARKER;
        cfg_wdata = 32'd0;
        pace_tx = 1'b0;
        stall_rx = 1'b0;
        failures = 0;
        bytes_sent = 0;
        body_seen = 0;
        verdicts_seen = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        reset_predictor();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_missing_marker();
        test_command_names();
        test_header_errors();
        test_body_limit();
        test_marker_values();
        test_random_traffic();

        drain_pipeline();
        repeat (8) @(posedge clk);
        $display("Sent %0d bytes; checked %0d forwarded body bytes and %0d frame verdicts.",
                 bytes_sent, body_seen, verdicts_seen);
        $display("Verdicts by status code 0 to 6: %0d %0d %0d %0d %0d %0d %0d",
                 status_seen[fdc_pkg::ST_OK], status_seen[fdc_pkg::ST_NO_MARKER],
                 status_seen[fdc_pkg::ST_BAD_COMMAND], status_seen[fdc_pkg::ST_BAD_GUID],
                 status_seen[fdc_pkg::ST_NUMBER_OVER], status_seen[fdc_pkg::ST_CRC_MISMATCH],
                 status_seen[fdc_pkg::ST_BODY_TOO_LONG]);
        if (failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### frame_deframer_crc32_check_top.f
hw/rtl/fdc_pkg.sv
hw/rtl/fdc_crc.sv
hw/rtl/fdc_parser.sv
hw/rtl/frame_deframer_crc32_check_top.sv
tb/tb_frame_deframer_crc32_check_top.sv
